// File: rtl/mt19_pkg.sv
`default_nettype none

package mt19_pkg;

    localparam int unsigned N_WORDS = 624;
    localparam int unsigned M_OFFSET = 397;
    localparam int unsigned IDX_W = 10;

    localparam logic [31:0] INIT_MULT = 32'd1812433253;
    localparam logic [31:0] MATRIX_A = 32'h9908b0df;
    localparam logic [31:0] UPPER_MASK = 32'h80000000;
    localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C = 32'hefc60000;
    localparam logic [31:0] SEED_RESET = 32'd5489;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);

    // push request from the seeding sequencer into the cell chain
    typedef struct packed {
        logic        busy;
        logic        push_valid;
        logic [31:0] push_data;
    } seed_ctrl_t;

    function automatic logic [31:0] twist(input logic [31:0] w0, input logic [31:0] w1,
                                          input logic [31:0] wm);
        logic [31:0] mix;
        mix = (w0 & UPPER_MASK) | (w1 & LOWER_MASK);
        twist = wm ^ (mix >> 1) ^ (mix[0] ? MATRIX_A : 32'd0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        temper = y;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mt19_cell.sv
`default_nettype none

module mt19_cell (
    input  wire logic        clk,
    input  wire logic        shift,
    input  wire logic [31:0] d,
    output logic      [31:0] q
);

    logic [31:0] word_reg;
    logic [31:0] word_next;

    always_comb
    begin
        word_next = shift ? d : word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

`default_nettype wire

// File: rtl/mt19_seeder.sv
`default_nettype none

module mt19_seeder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [31:0]       seed,
    input  wire logic [31:0]       prev,
    output mt19_pkg::seed_ctrl_t   ctrl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEED0 = 2'd1;
    localparam logic [1:0] S_MUL = 2'd2;
    localparam logic [1:0] S_ADD = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [mt19_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]                 prod_reg, prod_next;
    logic [31:0]                 prod_low;

    // only the low 32 bits of the product are kept
    assign prod_low = mt19_pkg::INIT_MULT * (prev ^ (prev >> 30));

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        prod_next = prod_reg;
        ctrl.busy = (state_reg != S_IDLE);
        ctrl.push_valid = 1'b0;
        ctrl.push_data = prod_reg + 32'(idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SEED0;
                end
            end
            S_SEED0:
            begin
                ctrl.push_valid = 1'b1;
                ctrl.push_data = seed;
                idx_next = mt19_pkg::IDX_W'(1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // prev is the word pushed last cycle, now at the chain tail
                prod_next = prod_low;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ctrl.push_valid = 1'b1;
                if (idx_reg == mt19_pkg::LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SEED0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

// File: rtl/mt19937_word_generator.sv
`default_nettype none

// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid / s_axis_tready s_axis_tdata[0] = restart
// m_axis    out        m_axis_tvalid / m_axis_tready m_axis_tdata[31:0] = random_word
// cfg       in         cfg_valid / cfg_ready         cfg_data[31:0] = seed
//
// an ordinary request is tempered into the output register; unless the output stalls
// or a refill runs, one word per cycle goes out, set by the single twist step at the
// head of the 624-cell chain; after reset and on every restart the chain is refilled
// from the seed (the seed word, then per word a multiply step and an add-and-push),
// s_axis_tready low; a restart request is held, its word comes out after the refill
// cfg_ready is always high; a new seed is used from the next restart, reset restores 5489

module mt19937_word_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] random_word
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned N = mt19_pkg::N_WORDS;

    logic [31:0]           seed_reg;
    logic                  pending_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;
    logic [31:0]           cell_q [N];
    logic [31:0]           tail_d;
    logic [31:0]           new_word;
    logic                  shift;
    logic                  out_free;
    logic                  in_accept;
    logic                  gen;
    logic                  start;
    mt19_pkg::seed_ctrl_t  sctrl;

    mt19_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .seed  (seed_reg),
        .prev  (cell_q[N-1]),
        .ctrl  (sctrl)
    );

    // cell 0 holds the oldest word; new words enter at the tail
    for (genvar k = 0; k < N; k++)
    begin : g_chain
        if (k == N - 1)
        begin : g_tail
            mt19_cell u_cell (.clk(clk), .shift(shift), .d(tail_d), .q(cell_q[k]));
        end
        else
        begin : g_body
            mt19_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[k+1]), .q(cell_q[k]));
        end
    end

    assign new_word = mt19_pkg::twist(cell_q[0], cell_q[1], cell_q[mt19_pkg::M_OFFSET]);

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !sctrl.busy && !pending_reg && out_free;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign start = in_accept && s_axis_tdata[0];
    assign gen = (in_accept && !s_axis_tdata[0]) || (pending_reg && !sctrl.busy && out_free);
    assign shift = gen || sctrl.push_valid;
    assign tail_d = sctrl.push_valid ? sctrl.push_data : new_word;

    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mt19_pkg::SEED_RESET;
            pending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= cfg_data;
            end
            if (start)
            begin
                pending_reg <= 1'b1;
            end
            else if (gen)
            begin
                pending_reg <= 1'b0;
            end
            if (gen)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            out_data_reg <= mt19_pkg::temper(new_word);
        end
    end

`ifndef SYNTH
    a_no_accept_while_seeding: assert property (@(posedge clk) disable iff (!rst_n)
        sctrl.busy |-> !s_axis_tready)
        else $error("request accepted during refill");

    a_no_gen_and_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(gen && sctrl.push_valid))
        else $error("twist and seed push in the same cycle");

    a_restart_held: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (pending_reg && sctrl.busy))
        else $error("restart request not held for refill");

    a_gen_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        gen |=> m_axis_tvalid)
        else $error("generated word not presented");
`endif

endmodule

`default_nettype wire
